// ===== design/tare_pkg.sv =====
// Shared constants, types and helper functions of the six-axis tare offset removal block.
package tare_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 10;
	localparam int NUM_AXES    = 6;
	localparam int CFG_BITS    = 10;
	localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;
	localparam int NORM_BITS   = SAMPLE_BITS + 1;
	localparam int STEP_BITS   = $clog2(SUM_BITS);
	localparam int IN_DATA_W   = ((NUM_AXES * SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((NUM_AXES * NORM_BITS + 7) / 8) * 8;
	localparam int OUT_USER_W  = 2;

	localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(50);
	localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

	// Bit positions inside the result tuser.
	localparam int USER_CALIBRATING = 0;
	localparam int USER_UPDATED     = 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_FIN,
		ST_EMIT
	} tare_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic div_step;
		logic div_fin;
		logic emit;
	} tare_cmd_t;

	typedef struct packed {
		logic func;
		logic cal_hit;
		logic out_free;
		logic cal_active;
	} tare_sts_t;

	// Sample count used for averaging: zero counts as one, large values saturate.
	function automatic logic [COUNT_BITS-1:0] eff_count(input logic [CFG_BITS-1:0] cfg);
		logic [31:0] c;
		c = 32'(cfg);
		if (c == 32'd0) begin
			c = 32'd1;
		end
		if (c > COUNT_MAX) begin
			c = COUNT_MAX;
		end
		return COUNT_BITS'(c);
	endfunction

endpackage

// ===== design/six_axis_tare_offset_removal.sv =====
// Top level of the six-axis force/torque tare offset removal block.
//
//  Channel   Direction  Handshake            Payload
//  s_axis    in         s_tvalid/s_tready    s_tdata: six raw samples; s_tuser: func
//  m_axis    out        m_tvalid/m_tready    m_tdata: six tared values; m_tuser: flags
//  cfg       in         cfg_we               cfg_wdata: calibration sample count
//
// One item is in flight at a time. A start command yields no beat; after its accept the
// controller passes through ST_EXEC and returns to ST_IDLE, where s_tready is high again.
// A sample raises the registered m_tvalid from ST_EMIT; when it completes a calibration
// it first passes through ST_DIV and ST_FIN: the six restoring dividers retire one
// quotient bit per cycle over all 26 bits of the sum, and ST_FIN then loads the offsets.
// The next beat is accepted only once the controller is back in ST_IDLE after the emit.
// The result sits in an output register, so a new beat is accepted while it waits;
// the next result waits in its final state until that register is taken.
// Reset is asynchronous and active low; it clears offsets, sums, count and flags and
// loads the sample count register with 50.
module six_axis_tare_offset_removal import tare_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write: calibration sample count.
	input  logic                  cfg_we,
	input  logic [CFG_BITS-1:0]   cfg_wdata,
	// Input beats.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// From bit 0: force_x, force_y, force_z, moment_x, moment_y, moment_z.
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// Bit 0: func (0 = sample, 1 = start calibration).
	input  logic                  s_tuser,
	// Result beats.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// From bit 0: norm_force_x, norm_force_y, norm_force_z, norm_moment_x,
	// norm_moment_y, norm_moment_z, then zero padding.
	output logic [OUT_DATA_W-1:0] m_tdata,
	// Bit 0: calibrating, bit 1: offsets_updated.
	output logic [OUT_USER_W-1:0] m_tuser
);

	tare_cmd_t cmd;
	tare_sts_t sts;

	// The controller decides when to capture, update, divide and emit.
	tare_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds all sums, offsets and the result register.
	tare_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// Only one item is worked on at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// A start command produces no result and leaves calibration running.
	a_start_no_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser) |=> ##1 (s_tready && sts.cal_active))
		else $error("start command did not return to idle with calibration active");

	// A beat that reports new offsets never also reports calibration in progress.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[USER_CALIBRATING] && m_tuser[USER_UPDATED]))
		else $error("offsets_updated set while still calibrating");

endmodule

// ===== design/tare_ctrl.sv =====
// Controller state machine that sequences capture, update, division and result output.
module tare_ctrl import tare_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  tare_sts_t sts,
	output tare_cmd_t cmd
);

	tare_state_t          state_q, state_d;
	logic [STEP_BITS-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				step_d   = '0;
				if (sts.func) begin
					state_d = ST_IDLE;
				end else if (sts.cal_hit) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_BITS'(SUM_BITS - 1)) begin
					state_d = ST_FIN;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_FIN: begin
				cmd.div_fin = 1'b1;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/tare_dp.sv =====
// Datapath: sample capture, running sums, six restoring dividers, offsets and result register.
module tare_dp import tare_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_BITS-1:0]   cfg_wdata,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  tare_cmd_t             cmd,
	output tare_sts_t             sts,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser
);

	logic [CFG_BITS-1:0]    cfg_q;
	logic                   active_q;
	logic                   upd_q;
	logic [COUNT_BITS-1:0]  count_q;
	logic [SUM_BITS-1:0]    sums_q [NUM_AXES];
	logic [SAMPLE_BITS-1:0] offs_q [NUM_AXES];

	logic                   func_q;
	logic [SAMPLE_BITS-1:0] raw_q  [NUM_AXES];
	logic [SUM_BITS-1:0]    dq_q   [NUM_AXES];
	logic [COUNT_BITS-1:0]  rem_q  [NUM_AXES];

	logic [SUM_BITS-1:0]    sum_next [NUM_AXES];
	logic [SUM_BITS-1:0]    dq_next  [NUM_AXES];
	logic [COUNT_BITS-1:0]  rem_next [NUM_AXES];
	logic [NORM_BITS-1:0]   norm     [NUM_AXES];
	logic [OUT_DATA_W-1:0]  out_word;

	logic                   all_zero;
	logic                   counting;
	logic [COUNT_BITS-1:0]  n_eff;
	logic [COUNT_BITS-1:0]  count_inc;
	logic                   cal_hit;

	assign n_eff     = eff_count(cfg_q);
	assign count_inc = count_q + 1'b1;

	always_comb begin
		logic [COUNT_BITS:0]    trial;
		logic                   ge;
		logic [SAMPLE_BITS-1:0] off;
		all_zero = 1'b1;
		out_word = '0;
		for (int i = 0; i < NUM_AXES; i++) begin
			if (raw_q[i] != '0) begin
				all_zero = 1'b0;
			end
			sum_next[i] = sums_q[i] + SUM_BITS'(raw_q[i]);
			// One restoring division step: shift in the next dividend bit and try n.
			trial       = {rem_q[i], dq_q[i][SUM_BITS-1]};
			ge          = (trial >= {1'b0, n_eff});
			rem_next[i] = ge ? COUNT_BITS'(trial - {1'b0, n_eff}) : COUNT_BITS'(trial);
			dq_next[i]  = {dq_q[i][SUM_BITS-2:0], ge};
			off         = active_q ? '0 : offs_q[i];
			norm[i]     = {1'b0, raw_q[i]} - {1'b0, off};
			out_word[i*NORM_BITS +: NORM_BITS] = norm[i];
		end
	end

	assign counting = !func_q && active_q && !all_zero;
	assign cal_hit  = counting && (count_inc >= n_eff);

	assign sts.func       = func_q;
	assign sts.cal_hit    = cal_hit;
	assign sts.out_free   = !m_tvalid || m_tready;
	assign sts.cal_active = active_q;

	// Architectural state with reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= CFG_RESET;
			active_q <= 1'b0;
			upd_q    <= 1'b0;
			count_q  <= '0;
			for (int i = 0; i < NUM_AXES; i++) begin
				sums_q[i] <= '0;
				offs_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				if (func_q) begin
					active_q <= 1'b1;
					count_q  <= '0;
					for (int i = 0; i < NUM_AXES; i++) begin
						sums_q[i] <= '0;
					end
				end else begin
					upd_q <= cal_hit;
					if (counting) begin
						count_q <= count_inc;
						for (int i = 0; i < NUM_AXES; i++) begin
							sums_q[i] <= sum_next[i];
						end
					end
					if (cal_hit) begin
						active_q <= 1'b0;
					end
				end
			end
			if (cmd.div_fin) begin
				for (int i = 0; i < NUM_AXES; i++) begin
					offs_q[i] <= dq_q[i][SAMPLE_BITS-1:0];
				end
			end
		end
	end

	// Working registers for the item in flight and the dividers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= s_tuser;
			for (int i = 0; i < NUM_AXES; i++) begin
				raw_q[i] <= s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
			end
		end
		for (int i = 0; i < NUM_AXES; i++) begin
			if (cmd.exec) begin
				dq_q[i]  <= sum_next[i];
				rem_q[i] <= '0;
			end else if (cmd.div_step) begin
				dq_q[i]  <= dq_next[i];
				rem_q[i] <= rem_next[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_tdata                   <= out_word;
			m_tuser[USER_CALIBRATING] <= active_q;
			m_tuser[USER_UPDATED]     <= upd_q;
		end
	end

endmodule
